/* hw/rtl/arf_pkg.sv */
// Shared types, codes and helper functions of the aspect-ratio rectangle fit.
package arf_pkg;

    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int PIPE_DEPTH = DIV_STAGES + 4;

    localparam logic [3:0] ALIGN_NONE      = 4'd0;
    localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd1;
    localparam logic [3:0] ALIGN_XMID_YMIN = 4'd2;
    localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd3;
    localparam logic [3:0] ALIGN_XMIN_YMID = 4'd4;
    localparam logic [3:0] ALIGN_XMID_YMID = 4'd5;
    localparam logic [3:0] ALIGN_XMAX_YMID = 4'd6;
    localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd7;
    localparam logic [3:0] ALIGN_XMID_YMAX = 4'd8;
    localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd9;

    typedef enum logic [1:0]
    {
        PART_MIN,
        PART_MID,
        PART_MAX
    } part_t;

    // Per-request data that rides alongside the divider stages.
    typedef struct packed
    {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        box_width;
        logic [30:0]        box_height;
        logic [14:0]        tex_width;
        logic [14:0]        tex_height;
        part_t              x_part;
        part_t              y_part;
        logic               slice_mode;
        logic               pass_box;
        logic               empty;
    } side_t;

    // Partial remainder and the dividend word that the quotient shifts into.
    typedef struct packed
    {
        logic [14:0] rem;
        logic [31:0] word;
    } div_state_t;

    function automatic div_state_t div_step(div_state_t s, logic [14:0] d);
        logic [15:0] r16;
        div_state_t  t;
        t = s;
        for (int i = 0; i < DIV_STEPS_PER_STAGE; i++)
        begin
            r16 = {t.rem, t.word[31]};
            if (r16 >= {1'b0, d})
            begin
                r16    = r16 - {1'b0, d};
                t.word = {t.word[30:0], 1'b1};
            end
            else
            begin
                t.word = {t.word[30:0], 1'b0};
            end
            t.rem = r16[14:0];
        end
        return t;
    endfunction

    function automatic part_t x_part_of(logic [3:0] a);
        part_t p;
        case (a)
            ALIGN_XMID_YMIN, ALIGN_XMID_YMID, ALIGN_XMID_YMAX: p = PART_MID;
            ALIGN_XMAX_YMIN, ALIGN_XMAX_YMID, ALIGN_XMAX_YMAX: p = PART_MAX;
            default: p = PART_MIN;
        endcase
        return p;
    endfunction

    function automatic part_t y_part_of(logic [3:0] a);
        part_t p;
        case (a)
            ALIGN_XMIN_YMID, ALIGN_XMID_YMID, ALIGN_XMAX_YMID: p = PART_MID;
            ALIGN_XMIN_YMAX, ALIGN_XMID_YMAX, ALIGN_XMAX_YMAX: p = PART_MAX;
            default: p = PART_MIN;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/arf_div.sv */
// Pipelined restoring divider, 31-bit dividend by 15-bit divisor, four bits per stage.
module arf_div
    import arf_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [30:0]           dividend,
    input  logic [14:0]           divisor,
    output logic [30:0]           quotient
);

    div_state_t  st_reg [DIV_STAGES];
    logic [14:0] d_reg  [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0] <= div_step('{rem: 15'd0, word: {1'b0, dividend}}, divisor);
            d_reg[0]  <= divisor;
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                st_reg[j] <= div_step(st_reg[j-1], d_reg[j-1]);
                d_reg[j]  <= d_reg[j-1];
            end
        end
    end

    assign quotient = st_reg[DIV_STAGES-1].word[30:0];

endmodule

/* hw/rtl/arf_fit.sv */
// Scale choice, multiply and alignment stages that turn the two scales into the rectangle.
module arf_fit
    import arf_pkg::*;
(
    input  logic        clk,
    input  logic [2:0]  en,
    input  side_t       side,
    input  logic [30:0] scale_w,
    input  logic [30:0] scale_h,
    output logic        valid_res,
    output logic [31:0] center_x,
    output logic [31:0] center_y,
    output logic [30:0] rect_width,
    output logic [30:0] rect_height
);

    localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

    // Compare stage.
    side_t       c_side_reg;
    logic        c_use_h_reg;
    logic [14:0] c_mul_a_reg;
    logic [30:0] c_mul_b_reg;
    logic        use_h_next;

    // Multiply stage.
    side_t       m_side_reg;
    logic [30:0] m_rw_reg;
    logic [30:0] m_rh_reg;
    logic [45:0] prod;
    logic [30:0] prod_sat;
    logic [30:0] rw_next;
    logic [30:0] rh_next;

    // Align stage.
    logic        valid_res_reg;
    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [30:0] rect_width_reg;
    logic [30:0] rect_height_reg;
    logic signed [33:0] dx, dy, ox, oy, cx, cy;
    logic [31:0] cx_sat, cy_sat;

    assign use_h_next = side.slice_mode ? (scale_w < scale_h) : (scale_w > scale_h);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c_side_reg  <= side;
            c_use_h_reg <= use_h_next;
            c_mul_a_reg <= use_h_next ? side.tex_width : side.tex_height;
            c_mul_b_reg <= use_h_next ? scale_h : scale_w;
        end
    end

    always_comb
    begin
        prod     = {31'd0, c_mul_a_reg} * {15'd0, c_mul_b_reg};
        prod_sat = (prod[45:31] != 15'd0) ? 31'h7FFFFFFF : prod[30:0];
        rw_next  = c_side_reg.box_width;
        rh_next  = c_side_reg.box_height;
        if (!c_side_reg.pass_box)
        begin
            if (c_use_h_reg)
            begin
                rw_next = prod_sat;
            end
            else
            begin
                rh_next = prod_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m_side_reg <= c_side_reg;
            m_rw_reg   <= rw_next;
            m_rh_reg   <= rh_next;
        end
    end

    always_comb
    begin
        dx = $signed({3'b000, m_side_reg.box_width}) - $signed({3'b000, m_rw_reg});
        dy = $signed({3'b000, m_side_reg.box_height}) - $signed({3'b000, m_rh_reg});
        // A middle alignment halves the slack, rounding toward zero.
        case (m_side_reg.x_part)
            PART_MID: ox = (dx + $signed({33'd0, dx[33]})) >>> 1;
            PART_MAX: ox = dx;
            default:  ox = '0;
        endcase
        case (m_side_reg.y_part)
            PART_MID: oy = (dy + $signed({33'd0, dy[33]})) >>> 1;
            PART_MAX: oy = dy;
            default:  oy = '0;
        endcase
        cx = $signed({{2{m_side_reg.pos_x[31]}}, m_side_reg.pos_x})
             + $signed({4'b0000, m_rw_reg[30:1]}) + ox;
        cy = $signed({{2{m_side_reg.pos_y[31]}}, m_side_reg.pos_y})
             + $signed({4'b0000, m_rh_reg[30:1]}) + oy;
        if (cx > S32_MAX)
        begin
            cx_sat = 32'h7FFFFFFF;
        end
        else if (cx < S32_MIN)
        begin
            cx_sat = 32'h80000000;
        end
        else
        begin
            cx_sat = cx[31:0];
        end
        if (cy > S32_MAX)
        begin
            cy_sat = 32'h7FFFFFFF;
        end
        else if (cy < S32_MIN)
        begin
            cy_sat = 32'h80000000;
        end
        else
        begin
            cy_sat = cy[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            valid_res_reg   <= !m_side_reg.empty;
            center_x_reg    <= m_side_reg.empty ? 32'd0 : cx_sat;
            center_y_reg    <= m_side_reg.empty ? 32'd0 : cy_sat;
            rect_width_reg  <= m_side_reg.empty ? 31'd0 : m_rw_reg;
            rect_height_reg <= m_side_reg.empty ? 31'd0 : m_rh_reg;
        end
    end

    assign valid_res   = valid_res_reg;
    assign center_x    = center_x_reg;
    assign center_y    = center_y_reg;
    assign rect_width  = rect_width_reg;
    assign rect_height = rect_height_reg;

endmodule

/* hw/rtl/aspect_ratio_rect_fit.sv */
// Top level of the aspect-ratio rectangle fit: request pipeline and its flow control.
// A request passes twelve register stages, counting the input and the output register.
// Throughput is one request per cycle unless the output stalls; the two scale dividers
// are fully pipelined.
// Each stage holds its own valid bit, so a stalled output only blocks until bubbles fill.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module aspect_ratio_rect_fit
    import arf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, lowest bit up: pos_x[31:0], pos_y[63:32], box_width[94:64],
    // box_height[125:95], tex_width[140:126], tex_height[155:141],
    // align_mode[159:156], slice_mode[160], defer_mode[161], zero pad[167:162].
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, lowest bit up: valid_res[0], center_x[32:1], center_y[64:33],
    // rect_width[95:65], rect_height[126:96], zero pad[127].
    output logic [127:0] m_tdata
);

    // Stage 0 registers the request, stages 1 to 8 run the dividers,
    // stage 9 picks the scale, stage 10 multiplies, stage 11 aligns and holds the result.
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] adv;
    side_t                 side_reg [DIV_STAGES+1];
    side_t                 side_next;
    logic [30:0]           scale_w;
    logic [30:0]           scale_h;
    logic                  valid_res;
    logic [31:0]           center_x;
    logic [31:0]           center_y;
    logic [30:0]           rect_width;
    logic [30:0]           rect_height;

    // A stage may load whenever it is empty or its own content moves on.
    always_comb
    begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Decode the request. With no alignment or with defer the box passes unchanged
    // and no alignment offset is applied.
    always_comb
    begin
        side_next.pos_x      = s_tdata[31:0];
        side_next.pos_y      = s_tdata[63:32];
        side_next.box_width  = s_tdata[94:64];
        side_next.box_height = s_tdata[125:95];
        side_next.tex_width  = s_tdata[140:126];
        side_next.tex_height = s_tdata[155:141];
        side_next.slice_mode = s_tdata[160];
        side_next.pass_box   = s_tdata[161] || (s_tdata[159:156] == ALIGN_NONE);
        side_next.x_part     = side_next.pass_box ? PART_MIN : x_part_of(s_tdata[159:156]);
        side_next.y_part     = side_next.pass_box ? PART_MIN : y_part_of(s_tdata[159:156]);
        side_next.empty      = (s_tdata[94:64] == 31'd0) || (s_tdata[125:95] == 31'd0)
                               || (s_tdata[140:126] == 15'd0) || (s_tdata[155:141] == 15'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= side_next;
        end
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            if (adv[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // The integer scale (box << 16) / (tex << 16) reduces to box / tex.
    arf_div u_div_w
    (
        .clk      (clk),
        .en       (adv[DIV_STAGES:1]),
        .dividend (side_reg[0].box_width),
        .divisor  (side_reg[0].tex_width),
        .quotient (scale_w)
    );

    arf_div u_div_h
    (
        .clk      (clk),
        .en       (adv[DIV_STAGES:1]),
        .dividend (side_reg[0].box_height),
        .divisor  (side_reg[0].tex_height),
        .quotient (scale_h)
    );

    arf_fit u_fit
    (
        .clk         (clk),
        .en          (adv[PIPE_DEPTH-1:DIV_STAGES+1]),
        .side        (side_reg[DIV_STAGES]),
        .scale_w     (scale_w),
        .scale_h     (scale_h),
        .valid_res   (valid_res),
        .center_x    (center_x),
        .center_y    (center_y),
        .rect_width  (rect_width),
        .rect_height (rect_height)
    );

    assign m_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_tdata  = {1'b0, rect_height, rect_width, center_y, center_x, valid_res};

endmodule

/* hw/rtl/arf_checker.sv */
// Port-level checks of the aspect-ratio rectangle fit and their binding.
module arf_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // A result that waits keeps its content.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty box or texture reports all-zero fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[127:1] == 127'd0)
        else $error("invalid result carries nonzero fields");

    // Once reset has been seen at an edge, no result is offered at the next one.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

endmodule

bind aspect_ratio_rect_fit arf_checker u_arf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
